/* design/bwu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bwu_pkg: shared types and codes for the breakpoint/watchpoint unit
// Operation, kind and run mode codes, the command passed from the front to the
// back, and the result item.
// ----------------------------------------------------------------------------
package bwu_pkg;

	// table sizes
	localparam int unsigned BREAK_SLOTS_DEF = 16;
	localparam int unsigned WATCH_SLOTS_DEF = 8;

	// field widths
	localparam int unsigned ADDR_W = 32;

	// operation codes on the func field
	localparam logic [2:0] FN_INSERT = 3'd0;
	localparam logic [2:0] FN_REMOVE = 3'd1;
	localparam logic [2:0] FN_CLEAR  = 3'd2;
	localparam logic [2:0] FN_PC     = 3'd3;
	localparam logic [2:0] FN_MEM    = 3'd4;

	// entry kinds on the kind field
	localparam logic [2:0] KD_SW_BREAK = 3'd0;
	localparam logic [2:0] KD_HW_BREAK = 3'd1;
	localparam logic [2:0] KD_WRITE    = 3'd2;
	localparam logic [2:0] KD_READ     = 3'd3;
	localparam logic [2:0] KD_ACCESS   = 3'd4;

	// run modes
	localparam logic [2:0] RM_DETACH    = 3'd0;
	localparam logic [2:0] RM_STEP      = 3'd1;
	localparam logic [2:0] RM_INIT      = 3'd2;
	localparam logic [2:0] RM_BACK_STEP = 3'd3;

	// watch entry types as stored
	localparam logic [1:0] WT_WRITE  = 2'd0;
	localparam logic [1:0] WT_READ   = 2'd1;
	localparam logic [1:0] WT_ACCESS = 2'd2;

	// decoded operation
	typedef enum logic [2:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_CLEAR,
		OP_PC,
		OP_MEM,
		OP_BAD
	} op_t;

	// what a pc check does
	typedef enum logic [1:0] {
		PCM_NONE,
		PCM_STEP,
		PCM_SCAN
	} pc_mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNSUP = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		STOP_NONE  = 2'd0,
		STOP_STEP  = 2'd1,
		STOP_BREAK = 2'd2
	} stop_t;

	// classified command, front to back
	typedef struct packed {
		op_t               op;
		logic              tgt_break;
		logic [1:0]        wtype;
		pc_mode_t          pc_mode;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W:0]   wend;
	} cmd_t;

	// result item
	typedef struct packed {
		status_t    status;
		stop_t      pc_stop;
		logic       watch_hit;
		logic [2:0] watch_slot;
	} res_t;

endpackage

`default_nettype wire

/* design/bwu_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bwu_fifo: two-entry queue
// Holds up to two items of any packed type; registered storage, head on the
// output while not empty.
// ----------------------------------------------------------------------------
module bwu_fifo #(
	parameter type T = logic
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire T     wdata,
	output logic      full,
	input  wire logic pop,
	output T          rdata,
	output logic      empty
);

	T           mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	// transfer qualifiers
	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/bwu_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bwu_front: accept and classify
// Decodes each accepted item into a command (operation, target table, watch
// type, pc check mode, range end) and queues it for the back end.
// ----------------------------------------------------------------------------
module bwu_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [2:0]            func,
	input  wire logic [2:0]            kind,
	input  wire logic [31:0]           addr,
	input  wire logic [31:0]           length,
	input  wire logic [2:0]            run_mode,
	output bwu_pkg::cmd_t              cmd,
	output logic                       cmd_empty,
	input  wire logic                  cmd_pop
);

	bwu_pkg::cmd_t cmd_d;
	logic          kind_ok;

	// classify the incoming item
	always_comb begin
		kind_ok         = (kind <= bwu_pkg::KD_ACCESS);
		cmd_d.tgt_break = (kind <= bwu_pkg::KD_HW_BREAK);
		cmd_d.wtype     = 2'(kind - bwu_pkg::KD_WRITE);
		cmd_d.addr      = addr;
		cmd_d.wend      = {1'b0, addr} + {1'b0, length};

		unique case (func)
			bwu_pkg::FN_INSERT: cmd_d.op = kind_ok ? bwu_pkg::OP_INSERT : bwu_pkg::OP_BAD;
			bwu_pkg::FN_REMOVE: cmd_d.op = kind_ok ? bwu_pkg::OP_REMOVE : bwu_pkg::OP_BAD;
			bwu_pkg::FN_CLEAR:  cmd_d.op = bwu_pkg::OP_CLEAR;
			bwu_pkg::FN_PC:     cmd_d.op = bwu_pkg::OP_PC;
			bwu_pkg::FN_MEM:    cmd_d.op = bwu_pkg::OP_MEM;
			default:            cmd_d.op = bwu_pkg::OP_BAD;
		endcase

		unique case (run_mode) inside
			bwu_pkg::RM_DETACH: cmd_d.pc_mode = bwu_pkg::PCM_NONE;
			bwu_pkg::RM_STEP, bwu_pkg::RM_INIT, bwu_pkg::RM_BACK_STEP: begin
				cmd_d.pc_mode = bwu_pkg::PCM_STEP;
			end
			default:            cmd_d.pc_mode = bwu_pkg::PCM_SCAN;
		endcase
	end

	// command queue toward the back end
	bwu_fifo #(
		.T(bwu_pkg::cmd_t)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_d),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (cmd_empty)
	);

endmodule

`default_nettype wire

/* design/bwu_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bwu_back: table execution
// Holds the breakpoint and watchpoint tables, one comparator per entry; runs
// one command per cycle unless the result queue is full and queues the result.
// ----------------------------------------------------------------------------
module bwu_back #(
	parameter int unsigned BREAK_SLOTS = bwu_pkg::BREAK_SLOTS_DEF,
	parameter int unsigned WATCH_SLOTS = bwu_pkg::WATCH_SLOTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bwu_pkg::cmd_t cmd,
	input  wire logic          cmd_empty,
	output logic               cmd_pop,
	input  wire logic          res_pop,
	output bwu_pkg::res_t      res,
	output logic               res_empty
);

	localparam int unsigned BCW = $clog2(BREAK_SLOTS + 1);
	localparam int unsigned WCW = $clog2(WATCH_SLOTS + 1);
	localparam int unsigned WIW = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;

	// tables
	logic [31:0]    brk_q  [BREAK_SLOTS];
	logic [31:0]    wbeg_q [WATCH_SLOTS];
	logic [32:0]    wend_q [WATCH_SLOTS];
	logic [1:0]     wtyp_q [WATCH_SLOTS];
	logic [BCW-1:0] brk_cnt_q;
	logic [WCW-1:0] wch_cnt_q;

	logic                   go;
	logic                   res_full;
	logic [BREAK_SLOTS-1:0] brk_eq;
	logic [BREAK_SLOTS-1:0] brk_shift;
	logic [WATCH_SLOTS-1:0] wch_eq;
	logic [WATCH_SLOTS-1:0] wch_hit;
	logic [WATCH_SLOTS-1:0] wch_shift;
	logic                   brk_full;
	logic                   wch_full;
	logic [WIW-1:0]         wch_first;
	logic                   ins_brk;
	logic                   ins_wch;
	logic                   rm_brk;
	logic                   rm_wch;
	logic                   clr;
	bwu_pkg::res_t          res_d;

	assign go      = !cmd_empty && !res_full;
	assign cmd_pop = go;

	// per-entry comparators
	always_comb begin
		logic brk_pre;
		logic wch_pre;
		brk_pre = 1'b0;
		for (int i = 0; i < BREAK_SLOTS; i++) begin
			brk_eq[i]    = (BCW'(i) < brk_cnt_q) && (brk_q[i] == cmd.addr);
			brk_pre      = brk_pre | brk_eq[i];
			brk_shift[i] = brk_pre;
		end
		wch_pre = 1'b0;
		for (int i = 0; i < WATCH_SLOTS; i++) begin
			wch_eq[i]    = (WCW'(i) < wch_cnt_q) && (wbeg_q[i] == cmd.addr)
				&& (wend_q[i] == cmd.wend) && (wtyp_q[i] == cmd.wtype);
			wch_hit[i]   = (WCW'(i) < wch_cnt_q) && (cmd.addr >= wbeg_q[i])
				&& ({1'b0, cmd.addr} < wend_q[i])
				&& ((wtyp_q[i] == bwu_pkg::WT_WRITE) || (wtyp_q[i] == bwu_pkg::WT_ACCESS));
			wch_pre      = wch_pre | wch_eq[i];
			wch_shift[i] = wch_pre;
		end
		// lowest hitting slot
		wch_first = '0;
		for (int i = WATCH_SLOTS - 1; i >= 0; i--) begin
			if (wch_hit[i]) begin
				wch_first = WIW'(i);
			end
		end
	end

	assign brk_full = (brk_cnt_q == BCW'(BREAK_SLOTS));
	assign wch_full = (wch_cnt_q == WCW'(WATCH_SLOTS));

	// table update strobes
	assign ins_brk = go && (cmd.op == bwu_pkg::OP_INSERT) && cmd.tgt_break && !brk_full;
	assign ins_wch = go && (cmd.op == bwu_pkg::OP_INSERT) && !cmd.tgt_break && !wch_full;
	assign rm_brk  = go && (cmd.op == bwu_pkg::OP_REMOVE) && cmd.tgt_break && (|brk_eq);
	assign rm_wch  = go && (cmd.op == bwu_pkg::OP_REMOVE) && !cmd.tgt_break && (|wch_eq);
	assign clr     = go && (cmd.op == bwu_pkg::OP_CLEAR);

	// result of the current command
	always_comb begin
		res_d.status     = bwu_pkg::ST_OK;
		res_d.pc_stop    = bwu_pkg::STOP_NONE;
		res_d.watch_hit  = 1'b0;
		res_d.watch_slot = 3'd0;
		unique case (cmd.op)
			bwu_pkg::OP_INSERT: begin
				if (cmd.tgt_break ? brk_full : wch_full) begin
					res_d.status = bwu_pkg::ST_FULL;
				end
			end
			bwu_pkg::OP_PC: begin
				unique case (cmd.pc_mode)
					bwu_pkg::PCM_STEP: res_d.pc_stop = bwu_pkg::STOP_STEP;
					bwu_pkg::PCM_SCAN: begin
						res_d.pc_stop = (|brk_eq) ? bwu_pkg::STOP_BREAK : bwu_pkg::STOP_NONE;
					end
					default:           res_d.pc_stop = bwu_pkg::STOP_NONE;
				endcase
			end
			bwu_pkg::OP_MEM: begin
				res_d.watch_hit  = |wch_hit;
				res_d.watch_slot = (|wch_hit) ? 3'(wch_first) : 3'd0;
			end
			bwu_pkg::OP_BAD:    res_d.status = bwu_pkg::ST_UNSUP;
			default:            res_d.status = bwu_pkg::ST_OK;
		endcase
	end

	// breakpoint entries: shift down on remove, append on insert
	always_ff @(posedge clk) begin
		if (rm_brk) begin
			for (int i = 0; i < BREAK_SLOTS - 1; i++) begin
				if (brk_shift[i]) begin
					brk_q[i] <= brk_q[i + 1];
				end
			end
		end
		if (ins_brk) begin
			for (int i = 0; i < BREAK_SLOTS; i++) begin
				if (brk_cnt_q == BCW'(i)) begin
					brk_q[i] <= cmd.addr;
				end
			end
		end
	end

	// watchpoint entries: shift down on remove, append on insert
	always_ff @(posedge clk) begin
		if (rm_wch) begin
			for (int i = 0; i < WATCH_SLOTS - 1; i++) begin
				if (wch_shift[i]) begin
					wbeg_q[i] <= wbeg_q[i + 1];
					wend_q[i] <= wend_q[i + 1];
					wtyp_q[i] <= wtyp_q[i + 1];
				end
			end
		end
		if (ins_wch) begin
			for (int i = 0; i < WATCH_SLOTS; i++) begin
				if (wch_cnt_q == WCW'(i)) begin
					wbeg_q[i] <= cmd.addr;
					wend_q[i] <= cmd.wend;
					wtyp_q[i] <= cmd.wtype;
				end
			end
		end
	end

	// fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brk_cnt_q <= '0;
			wch_cnt_q <= '0;
		end else if (clr) begin
			brk_cnt_q <= '0;
			wch_cnt_q <= '0;
		end else begin
			if (ins_brk) begin
				brk_cnt_q <= brk_cnt_q + BCW'(1);
			end else if (rm_brk) begin
				brk_cnt_q <= brk_cnt_q - BCW'(1);
			end
			if (ins_wch) begin
				wch_cnt_q <= wch_cnt_q + WCW'(1);
			end else if (rm_wch) begin
				wch_cnt_q <= wch_cnt_q - WCW'(1);
			end
		end
	end

	// result queue
	bwu_fifo #(
		.T(bwu_pkg::res_t)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (go),
		.wdata (res_d),
		.full  (res_full),
		.pop   (res_pop),
		.rdata (res),
		.empty (res_empty)
	);

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(brk_cnt_q <= BCW'(BREAK_SLOTS)) && (wch_cnt_q <= WCW'(WATCH_SLOTS)))
		else $error("table count beyond capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (brk_cnt_q == '0) && (wch_cnt_q == '0))
		else $error("clear left entries in a table");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (cmd.op == bwu_pkg::OP_INSERT) && cmd.tgt_break && brk_full)
		|=> $stable(brk_cnt_q))
		else $error("insert into full breakpoint table changed its count");

	a_stop_only_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (cmd.op != bwu_pkg::OP_PC)) |-> (res_d.pc_stop == bwu_pkg::STOP_NONE))
		else $error("stop reported outside a pc check");

	a_hit_only_mem: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (cmd.op != bwu_pkg::OP_MEM)) |-> !res_d.watch_hit && (res_d.watch_slot == 3'd0))
		else $error("watch hit reported outside a memory check");

endmodule

`default_nettype wire

/* design/breakpoint_watchpoint_unit_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// breakpoint_watchpoint_unit_top: breakpoint and watchpoint comparator
// Front end classifies and queues operations, back end runs them against the
// breakpoint and watchpoint tables and queues the results.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result, in order. The unit sustains one
// item per clock while the result queue is not full: every table entry has its
// own comparator, so a pc check, memory check, insert, remove (find plus
// shift-down) or clear is done by the back end as it pops the command. An item
// is written into the command queue when taken; the back end then runs it and
// writes its result into the result queue, whose head is on the result ports.
// Two-entry queues on both sides let input and output stall on their own.
// After reset both tables are empty; only the entry counts are reset, so no
// clearing pass is needed and items are taken right away.
module breakpoint_watchpoint_unit_top #(
	parameter int unsigned BREAK_SLOTS = bwu_pkg::BREAK_SLOTS_DEF,
	parameter int unsigned WATCH_SLOTS = bwu_pkg::WATCH_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  func,
	input  wire logic [2:0]  kind,
	input  wire logic [31:0] addr,
	input  wire logic [31:0] length,
	input  wire logic [2:0]  run_mode,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       status,
	output logic [1:0]       pc_stop,
	output logic             watch_hit,
	output logic [2:0]       watch_slot
);

	bwu_pkg::cmd_t cmd;
	logic          cmd_empty;
	logic          cmd_pop;
	bwu_pkg::res_t res;

	// accept and classify
	bwu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.func     (func),
		.kind     (kind),
		.addr     (addr),
		.length   (length),
		.run_mode (run_mode),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop)
	);

	// execute against the tables
	bwu_back #(
		.BREAK_SLOTS(BREAK_SLOTS),
		.WATCH_SLOTS(WATCH_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_pop  (pop),
		.res      (res),
		.res_empty(empty)
	);

	// result fields
	assign status     = res.status;
	assign pc_stop    = res.pc_stop;
	assign watch_hit  = res.watch_hit;
	assign watch_slot = res.watch_slot;

endmodule

`default_nettype wire
